// ===== rtl/i2cmb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package i2cmb_pkg;

   // Width of the per-unit tick counter.
   localparam int DELAY_COUNT_WIDTH = 16;
   localparam int UNIT_WIDTH        = 16;
   localparam logic [UNIT_WIDTH-1:0] UNIT_RESET = UNIT_WIDTH'(8);

   // Largest value the tick counter can hold, in a width that fits any counter width.
   localparam logic [32:0] CNT_MAX_WIDE = (33'd1 << DELAY_COUNT_WIDTH) - 33'd1;

   // Command queue between the front and the back.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_WIDTH  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_WIDTH  = $clog2(QUEUE_DEPTH + 1);

   // Request codes on the input channel.
   localparam logic [1:0] REQ_WRITE = 2'd0;
   localparam logic [1:0] REQ_READ  = 2'd1;
   localparam logic [1:0] REQ_TICK  = 2'd2;

   localparam int BYTE_BITS = 8;

   typedef enum logic [1:0] {
      OP_WRITE,
      OP_READ,
      OP_TICK,
      OP_NOP
   } op_type;

   // Sequencer phases: start S0..S4, bit write W0..W5, bit read R0..R4, stop P0..P4.
   typedef enum logic [4:0] {
      PH_IDLE = 5'd0,
      PH_S0   = 5'd1,
      PH_S1   = 5'd2,
      PH_S2   = 5'd3,
      PH_S3   = 5'd4,
      PH_S4   = 5'd5,
      PH_W0   = 5'd6,
      PH_W1   = 5'd7,
      PH_W2   = 5'd8,
      PH_W3   = 5'd9,
      PH_W4   = 5'd10,
      PH_W5   = 5'd11,
      PH_R0   = 5'd12,
      PH_R1   = 5'd13,
      PH_R2   = 5'd14,
      PH_R3   = 5'd15,
      PH_R4   = 5'd16,
      PH_P0   = 5'd17,
      PH_P1   = 5'd18,
      PH_P2   = 5'd19,
      PH_P3   = 5'd20,
      PH_P4   = 5'd21
   } phase_type;

   typedef struct packed {
      logic [1:0] req_type;
      logic [7:0] tx_byte;
      logic       send_start;
      logic       send_stop;
      logic       give_ack;
      logic       sda_in;
   } req_word_type;

   typedef struct packed {
      logic       scl_out;
      logic       sda_out;
      logic       busy_res;
      logic       done_res;
      logic [7:0] rx_byte;
      logic       slave_acked;
      logic       cmd_rejected;
   } rsp_word_type;

   // Classified word held in the command queue.
   typedef struct packed {
      op_type     op;
      logic [7:0] tx_byte;
      logic       send_start;
      logic       send_stop;
      logic       give_ack;
      logic       sda_in;
   } queue_word_type;

endpackage

`default_nettype wire

// ===== rtl/i2cmb_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module i2cmb_front
   import i2cmb_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   output logic                req_ready,
   input  wire req_word_type   req_data,
   output logic                q_valid,
   output queue_word_type      q_word,
   input  wire logic           q_pop
);

   queue_word_type               entry_ff [QUEUE_DEPTH];
   logic [QPTR_WIDTH-1:0]        wr_ptr_ff;
   logic [QPTR_WIDTH-1:0]        wr_ptr_in;
   logic [QPTR_WIDTH-1:0]        rd_ptr_ff;
   logic [QPTR_WIDTH-1:0]        rd_ptr_in;
   logic [QCNT_WIDTH-1:0]        count_ff;
   logic [QCNT_WIDTH-1:0]        count_in;
   queue_word_type               classified;
   logic                         push;

   // Classify the request code into an operation.
   always_comb begin
      classified.tx_byte    = req_data.tx_byte;
      classified.send_start = req_data.send_start;
      classified.send_stop  = req_data.send_stop;
      classified.give_ack   = req_data.give_ack;
      classified.sda_in     = req_data.sda_in;
      unique case (req_data.req_type)
         REQ_WRITE: classified.op = OP_WRITE;
         REQ_READ:  classified.op = OP_READ;
         REQ_TICK:  classified.op = OP_TICK;
         default:   classified.op = OP_NOP;
      endcase
   end

   assign req_ready = (count_ff != QCNT_WIDTH'(QUEUE_DEPTH));
   assign push      = req_valid && req_ready;
   assign q_valid   = (count_ff != '0);
   assign q_word    = entry_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 :
                     wr_ptr_ff + QPTR_WIDTH'(1);
      end
      if (q_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 :
                     rd_ptr_ff + QPTR_WIDTH'(1);
      end
      if (push && !q_pop) begin
         count_in = count_ff + QCNT_WIDTH'(1);
      end else if (!push && q_pop) begin
         count_in = count_ff - QCNT_WIDTH'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= classified;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/i2cmb_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module i2cmb_back
   import i2cmb_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_we,
   input  wire logic [UNIT_WIDTH-1:0] csr_wdata,
   input  wire logic                  q_valid,
   input  wire queue_word_type        q_word,
   output logic                       q_pop,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output rsp_word_type               rsp_data
);

   phase_type                     phase_ff;
   phase_type                     phase_in;
   logic [DELAY_COUNT_WIDTH-1:0]  cnt_ff;
   logic [DELAY_COUNT_WIDTH-1:0]  cnt_in;
   logic [7:0]                    shift_ff;
   logic [7:0]                    shift_in;
   logic [3:0]                    bit_ff;
   logic [3:0]                    bit_in;
   logic                          op_read_ff;
   logic                          op_read_in;
   logic                          stop_ff;
   logic                          stop_in;
   logic                          ack_ff;
   logic                          ack_in;
   logic                          scl_ff;
   logic                          scl_in;
   logic                          sda_ff;
   logic                          sda_in_lvl;
   logic [UNIT_WIDTH-1:0]         unit_ff;
   logic                          rsp_valid_ff;
   rsp_word_type                  rsp_ff;
   rsp_word_type                  rsp_in;
   logic [DELAY_COUNT_WIDTH-1:0]  reload;
   logic [32:0]                   reload_wide;
   logic                          enter_en;
   phase_type                     enter_ph;
   logic                          done;
   logic                          rejected;

   // Counter reload for one delay unit; a zero unit counts as one tick.
   always_comb begin
      reload_wide = (unit_ff == '0) ? 33'd0 : 33'(unit_ff - UNIT_WIDTH'(1));
      reload = (reload_wide > CNT_MAX_WIDE) ? DELAY_COUNT_WIDTH'(CNT_MAX_WIDE) :
               reload_wide[DELAY_COUNT_WIDTH-1:0];
   end

   // A word leaves the queue whenever the output register is free or being emptied.
   assign q_pop     = q_valid && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Sequencer next state for the word at the head of the queue.
   always_comb begin
      phase_in   = phase_ff;
      cnt_in     = cnt_ff;
      shift_in   = shift_ff;
      bit_in     = bit_ff;
      op_read_in = op_read_ff;
      stop_in    = stop_ff;
      ack_in     = ack_ff;
      scl_in     = scl_ff;
      sda_in_lvl = sda_ff;
      enter_en   = 1'b0;
      enter_ph   = PH_IDLE;
      done       = 1'b0;
      rejected   = 1'b0;

      unique case (q_word.op)
         OP_WRITE, OP_READ: begin
            if (phase_ff != PH_IDLE) begin
               rejected = 1'b1;
            end else begin
               op_read_in = (q_word.op == OP_READ);
               stop_in    = q_word.send_stop;
               bit_in     = '0;
               enter_en   = 1'b1;
               if (q_word.op == OP_READ) begin
                  shift_in = '0;
                  ack_in   = q_word.give_ack;
                  enter_ph = PH_R0;
               end else begin
                  shift_in = q_word.tx_byte;
                  ack_in   = 1'b0;
                  enter_ph = q_word.send_start ? PH_S0 : PH_W0;
               end
            end
         end
         OP_TICK: begin
            if (phase_ff != PH_IDLE) begin
               if (cnt_ff != '0) begin
                  cnt_in = cnt_ff - DELAY_COUNT_WIDTH'(1);
               end else if (phase_ff == PH_W5) begin
                  // End of a written bit: the ninth bit of a read closes the byte.
                  scl_in = 1'b0;
                  bit_in = bit_ff + 4'd1;
                  if (op_read_ff) begin
                     if (stop_ff) begin
                        enter_en = 1'b1;
                        enter_ph = PH_P0;
                     end else begin
                        phase_in = PH_IDLE;
                        done     = 1'b1;
                     end
                  end else begin
                     shift_in = {shift_ff[6:0], 1'b0};
                     enter_en = 1'b1;
                     enter_ph = (bit_in < 4'd8) ? PH_W0 : PH_R0;
                  end
               end else if (phase_ff == PH_R4) begin
                  // End of a read bit: the ninth bit of a write is the acknowledge.
                  scl_in = 1'b0;
                  if (!op_read_ff) begin
                     ack_in = !q_word.sda_in;
                     if (stop_ff) begin
                        enter_en = 1'b1;
                        enter_ph = PH_P0;
                     end else begin
                        phase_in = PH_IDLE;
                        done     = 1'b1;
                     end
                  end else begin
                     shift_in = {shift_ff[6:0], q_word.sda_in};
                     bit_in   = bit_ff + 4'd1;
                     enter_en = 1'b1;
                     enter_ph = (bit_in < 4'd8) ? PH_R0 : PH_W0;
                  end
               end else if (phase_ff == PH_P4) begin
                  phase_in = PH_IDLE;
                  done     = 1'b1;
               end else begin
                  enter_en = 1'b1;
                  enter_ph = phase_type'(phase_ff + 5'd1);
               end
            end
         end
         default: begin
         end
      endcase

      // Entering a phase applies its pin levels and starts a new unit.
      if (enter_en) begin
         phase_in = enter_ph;
         cnt_in   = reload;
         unique case (enter_ph)
            PH_S0: begin
               scl_in     = 1'b1;
               sda_in_lvl = 1'b1;
            end
            PH_S2:   sda_in_lvl = 1'b0;
            PH_S4:   scl_in     = 1'b0;
            PH_W0:   sda_in_lvl = op_read_in ? !ack_in : shift_in[BYTE_BITS-1];
            PH_W1:   scl_in     = 1'b1;
            PH_R0:   sda_in_lvl = 1'b1;
            PH_R2:   scl_in     = 1'b1;
            PH_P0:   sda_in_lvl = 1'b0;
            PH_P2:   scl_in     = 1'b1;
            PH_P4:   sda_in_lvl = 1'b1;
            default: begin
            end
         endcase
      end

      rsp_in.scl_out      = scl_in;
      rsp_in.sda_out      = sda_in_lvl;
      rsp_in.busy_res     = (phase_in != PH_IDLE);
      rsp_in.done_res     = done;
      rsp_in.rx_byte      = (done && op_read_in) ? shift_in : 8'd0;
      rsp_in.slave_acked  = done && !op_read_in && ack_in;
      rsp_in.cmd_rejected = rejected;
   end

   // State machine register.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
      end else if (q_pop) begin
         phase_ff <= phase_in;
      end
   end

   // Sequencer datapath and bus levels.
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff     <= '0;
         shift_ff   <= '0;
         bit_ff     <= '0;
         op_read_ff <= 1'b0;
         stop_ff    <= 1'b0;
         ack_ff     <= 1'b0;
         scl_ff     <= 1'b1;
         sda_ff     <= 1'b1;
      end else if (q_pop) begin
         cnt_ff     <= cnt_in;
         shift_ff   <= shift_in;
         bit_ff     <= bit_in;
         op_read_ff <= op_read_in;
         stop_ff    <= stop_in;
         ack_ff     <= ack_in;
         scl_ff     <= scl_in;
         sda_ff     <= sda_in_lvl;
      end
   end

   // Delay unit register.
   always_ff @(posedge clock) begin
      if (reset) begin
         unit_ff <= UNIT_RESET;
      end else if (csr_we) begin
         unit_ff <= csr_wdata;
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (q_pop) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/i2c_master_byte_engine_top.sv =====
// A word accepted from the request side is written into the command queue, popped into the
// response register when that register is free or being emptied, and taken from there by the
// response side.
// Throughput: one word per cycle while the response side is ready, set by the bus sequencer.
// A two-word command queue lets the request side run while a response waits.
// Reset is synchronous and active high: queue and output empty, sequencer idle,
// SCL and SDA released, delay unit back to 8 ticks.
`timescale 1ns / 1ps
`default_nettype none

module i2c_master_byte_engine_top
   import i2cmb_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_we,
   input  wire logic [UNIT_WIDTH-1:0] csr_wdata,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire req_word_type          req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output rsp_word_type               rsp_data
);

   logic           q_valid;
   logic           q_pop;
   queue_word_type q_word;

   // Front end: accept and classify request words.
   i2cmb_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .q_valid   (q_valid),
      .q_word    (q_word),
      .q_pop     (q_pop)
   );

   // Back end: bus sequencer and response register.
   i2cmb_back u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .q_valid   (q_valid),
      .q_word    (q_word),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // A finished operation leaves the sequencer idle.
   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.done_res |-> !rsp_data.busy_res)
      else $error("done reported while still busy");

   // A dropped command never completes an operation.
   a_reject_not_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.cmd_rejected |-> !rsp_data.done_res)
      else $error("rejected command reported as done");

   // Received byte and acknowledge are only shown on completion.
   a_result_on_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.done_res |-> rsp_data.rx_byte == 8'd0 && !rsp_data.slave_acked)
      else $error("result fields set without done");

   // A full queue always has a word for the back end.
   a_full_has_word: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> q_valid)
      else $error("request stalled with an empty queue");

   // A word popped from the queue is shown on the response side next cycle.
   a_pop_shows: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> rsp_valid)
      else $error("popped word did not reach the output");

endmodule

`default_nettype wire
